/* sv/spq_pkg.sv */
// shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   localparam int KEY_W = 31;
   localparam int OCC_W = 5;
   localparam int STATUS_W = 2;

   typedef logic [KEY_W-1:0] key_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // control broadcast from the queue front end to every cell
   typedef struct packed {
      logic    insert;
      logic    pop;
      key_type new_key;
   } cell_ctl_type;

endpackage
`default_nettype wire

/* sv/spq_cell.sv */
// one cell of the sorted key chain: holds one key, compares it against the
// key being inserted and shifts with its neighbors; depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none
module spq_cell (
   input  wire logic                 clock,
   input  wire spq_pkg::cell_ctl_type ctl,
   input  wire logic                 in_use,
   input  wire spq_pkg::key_type     left_key,
   input  wire logic                 left_gt,
   input  wire spq_pkg::key_type     right_key,
   output spq_pkg::key_type          key,
   output logic                      gt
);

   spq_pkg::key_type key_ff;
   spq_pkg::key_type key_in;

   // empty slots count as greater: a largest key lands in the first free slot
   assign gt  = !in_use || (key_ff > ctl.new_key);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctl.insert) begin
         if (gt) begin
            key_in = left_gt ? left_key : ctl.new_key;
         end
      end else if (ctl.pop) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule
`default_nettype wire

/* sv/sorted_priority_queue_unit.sv */
// sorted priority queue: front end, fill count, result register and cell chain
// depends on spq_pkg and spq_cell
`timescale 1ns / 1ps
`default_nettype none
// usage
//   req channel: one word per operation; tuser[0] is the opcode (0 insert,
//   1 pop the smallest key), tdata[30:0] the key to insert.
//   rsp channel: one word per request; tuser is the status (0 ok, 1 pop on
//   empty, 2 insert dropped because full), tdata holds the popped key and
//   the occupancy after the operation.
//   keys sit in ascending order in a row of DEPTH cells; every cell compares
//   its key with the incoming one and moves left, right or holds in the same cycle.
//   the response is registered and shows in the cycle after the request is
//   taken. one request per cycle while the receiver keeps up, limited by the
//   single compare-and-shift step of the chain.
//   a new request is taken while a response waits, as long as that response
//   is taken in the same cycle; while the receiver stalls, req_tready drops
//   and the queue holds its contents.
//   reset empties the queue and drops any pending response; stored keys are
//   not cleared, the fill count alone marks which cells hold keys.
module sorted_priority_queue_unit #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // key[30:0], zero[31]
   input  wire logic [0:0]  req_tuser,  // opcode[0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // popped_key[30:0], occupancy[35:31], zero[39:36]
   output logic [1:0]       rsp_tuser   // status[1:0]
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   spq_pkg::status_type   status_ff;
   spq_pkg::status_type   status_in;
   spq_pkg::key_type      popped_ff;
   spq_pkg::key_type      popped_in;
   logic [spq_pkg::OCC_W-1:0] occ_ff;
   logic [spq_pkg::OCC_W-1:0] occ_in;
   logic [CNT_W+spq_pkg::OCC_W-1:0] count_ext;

   logic                  req_fire;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   spq_pkg::cell_ctl_type ctl;

   spq_pkg::key_type      cell_key [DEPTH];
   logic                  cell_gt  [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_pop     = (req_tuser[0] == spq_pkg::OP_POP);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   assign ctl.insert  = req_fire && !is_pop && !full;
   assign ctl.pop     = req_fire && is_pop && !empty;
   assign ctl.new_key = req_tdata[spq_pkg::KEY_W-1:0];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         spq_cell u_cell (
            .clock    (clock),
            .ctl      (ctl),
            .in_use   (count_ff > CNT_W'(g)),
            .left_key ((g == 0) ? cell_key[g] : cell_key[(g == 0) ? 0 : g-1]),
            .left_gt  ((g == 0) ? 1'b0 : cell_gt[(g == 0) ? 0 : g-1]),
            .right_key(cell_key[(g == DEPTH-1) ? g : g+1]),
            .key      (cell_key[g]),
            .gt       (cell_gt[g])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end

      count_ext = {{spq_pkg::OCC_W{1'b0}}, count_in};
      occ_in    = count_ext[spq_pkg::OCC_W-1:0];

      status_in = spq_pkg::ST_OK;
      if (req_fire && is_pop && empty) begin
         status_in = spq_pkg::ST_EMPTY;
      end else if (req_fire && !is_pop && full) begin
         status_in = spq_pkg::ST_FULL;
      end
      popped_in = ctl.pop ? cell_key[0] : '0;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         occ_ff    <= occ_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, occ_ff, popped_ff};
   assign rsp_tuser  = status_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_empty_pop : assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && empty) |=>
         (rsp_tvalid && rsp_tuser == spq_pkg::ST_EMPTY && rsp_tdata[30:0] == '0))
      else $error("pop on empty queue not reported");

   a_insert_count : assert property (@(posedge clock) disable iff (reset)
      (req_fire && !is_pop && !full) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the fill count");

   a_pop_head : assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_pop && !empty) |=> (rsp_tdata[30:0] == $past(cell_key[0])))
      else $error("pop did not return the head key");
`endif

endmodule
`default_nettype wire

/* tb/tb_sorted_priority_queue_unit.sv */
// testbench for sorted_priority_queue_unit: directed and random insert/pop words
// checked against a shadow sorted queue; depends on spq_pkg and the unit itself
`timescale 1ns / 1ps
module tb_sorted_priority_queue_unit;

   localparam int DEPTH = 16;
   localparam int RANDOM_WORDS = 830;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD = 60;

   // shadow copy of the queue contents; predicts one response word per request
   class spq_shadow_queue;
      typedef struct {
         spq_pkg::status_type          status;
         spq_pkg::key_type             popped;
         logic [spq_pkg::OCC_W-1:0]    occ;
      } rsp_fields_type;

      spq_pkg::key_type sorted_keys[$];
      rsp_fields_type   awaited_rsp[$];
      int unsigned      errors;
      int unsigned      checked;

      function new();
         errors = 0;
         checked = 0;
      endfunction

      function void apply_request(logic op, spq_pkg::key_type key);
         rsp_fields_type r;
         int             pos;
         r.popped = '0;
         if (op == spq_pkg::OP_INSERT) begin
            if (sorted_keys.size() >= DEPTH) begin
               r.status = spq_pkg::ST_FULL;
            end else begin
               // new key goes after any equal keys
               pos = 0;
               while (pos < sorted_keys.size() && sorted_keys[pos] <= key) pos++;
               sorted_keys.insert(pos, key);
               r.status = spq_pkg::ST_OK;
            end
         end else if (sorted_keys.size() == 0) begin
            r.status = spq_pkg::ST_EMPTY;
         end else begin
            r.popped = sorted_keys.pop_front();
            r.status = spq_pkg::ST_OK;
         end
         r.occ = spq_pkg::OCC_W'(sorted_keys.size());
         awaited_rsp.push_back(r);
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at response %0d: %s", checked, msg);
         errors++;
      endtask

      task check_response(logic [39:0] data, logic [1:0] user);
         rsp_fields_type want;
         if (awaited_rsp.size() == 0) begin
            report_mismatch("response word with no request outstanding");
         end else begin
            want = awaited_rsp.pop_front();
            if (user != want.status)
               report_mismatch($sformatf("status %0d, expected %0d", user, want.status));
            if (data[spq_pkg::KEY_W-1:0] != want.popped)
               report_mismatch($sformatf("popped key %h, expected %h",
                                         data[spq_pkg::KEY_W-1:0], want.popped));
            if (data[spq_pkg::KEY_W+spq_pkg::OCC_W-1:spq_pkg::KEY_W] != want.occ)
               report_mismatch($sformatf("occupancy %0d, expected %0d",
                  data[spq_pkg::KEY_W+spq_pkg::OCC_W-1:spq_pkg::KEY_W], want.occ));
         end
         checked++;
      endtask

      function int unsigned outstanding();
         return awaited_rsp.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // key[30:0], zero[31]
   logic [0:0]  req_tuser = '0;   // opcode[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // popped_key[30:0], occupancy[35:31], zero[39:36]
   logic [1:0]  rsp_tuser;        // status[1:0]

   spq_shadow_queue shadow = new();
   int unsigned     cycle_count = 0;

   sorted_priority_queue_unit #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #10 clock = ~clock;

   // offer one request word and hold it until the unit takes it
   task automatic send_word(logic op, spq_pkg::key_type key);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {1'b0, key};
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(op, key);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (shadow.outstanding() != 0) @(posedge clock);
   endtask

   // mix of duplicates, extremes and full-range keys
   function automatic spq_pkg::key_type random_key();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3, 4: return spq_pkg::key_type'($urandom_range(0, 31));
         default: return spq_pkg::key_type'($urandom);
      endcase
   endfunction

   // response side: stall pattern in segments, plus one long hold-off
   initial begin : receiver
      int unsigned mode;
      int unsigned seg_len;
      int unsigned hold_left;
      bit          hold_done;
      bit          ready;
      hold_left = 0;
      hold_done = 0;
      forever begin
         mode = $urandom_range(0, 3);
         seg_len = $urandom_range(5, 40);
         repeat (seg_len) begin
            @(posedge clock);
            if (!reset && rsp_tvalid && rsp_tready)
               shadow.check_response(rsp_tdata, rsp_tuser);
            case (mode)
               0: ready = 1'b1;
               1: ready = ($urandom_range(0, 99) < 70);
               2: ready = ($urandom_range(0, 99) < 30);
               default: ready = ~rsp_tready;
            endcase
            if (!hold_done && shadow.checked >= 300) begin
               hold_left = LONG_HOLD;
               hold_done = 1;
            end
            if (hold_left > 0) begin
               ready = 1'b0;
               hold_left--;
            end
            rsp_tready <= ready;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int unsigned insert_pct;
      int unsigned burst_left;
      logic        op;
      insert_pct = 50;
      burst_left = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty pop with key bits set, extremes, duplicates, then fill past full
      send_word(spq_pkg::OP_POP, '1);
      send_word(spq_pkg::OP_INSERT, '1);
      send_word(spq_pkg::OP_INSERT, '0);
      send_word(spq_pkg::OP_INSERT, '0);
      send_word(spq_pkg::OP_INSERT, 31'h5555_5555);
      send_word(spq_pkg::OP_INSERT, 31'h2AAA_AAAA);
      send_word(spq_pkg::OP_POP, 31'h1234_5678);
      for (int i = 0; i < 12; i++)
         send_word(spq_pkg::OP_INSERT, spq_pkg::key_type'(1000 - i * 7));
      send_word(spq_pkg::OP_INSERT, spq_pkg::key_type'(5));
      send_word(spq_pkg::OP_POP, '0);
      send_word(spq_pkg::OP_INSERT, 31'h7FFF_FFFE);
      send_word(spq_pkg::OP_INSERT, '0);
      wait_drained();

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // bias shifts so occupancy sweeps between empty and full
         if (n % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: insert_pct = 25;
               1: insert_pct = 50;
               2: insert_pct = 75;
               default: insert_pct = 90;
            endcase
         end
         if (n == 500) wait_drained();
         if (burst_left == 0) begin
            idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
            burst_left = $urandom_range(1, 24);
         end
         burst_left--;
         op = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_POP;
         send_word(op, random_key());
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (shadow.errors == 0 && shadow.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
